/* src/dtic_pkg.sv */
// dtic_pkg: shared types, register offsets and tables for the divider,
// timer and interrupt controller
// no dependencies
package dtic_pkg;

  // register offsets (low address byte)
  localparam logic [7:0] OFF_DIV  = 8'h04;
  localparam logic [7:0] OFF_TIMA = 8'h05;
  localparam logic [7:0] OFF_TMA  = 8'h06;
  localparam logic [7:0] OFF_TAC  = 8'h07;
  localparam logic [7:0] OFF_IF   = 8'h0F;
  localparam logic [7:0] OFF_IE   = 8'hFF;

  // access kinds carried in the input tuser bit
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam int IRQ_W      = 5;
  localparam int DIV_W      = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] TAC_ENABLE  = 8'h04;
  localparam logic [7:0] TIMER_IRQ   = 8'h04;
  localparam logic [7:0] UNMAPPED_RD = 8'hFF;

  // divider tap watched by the timer, per tac[1:0]
  localparam logic [3:0] EDGE_TAP [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

  // interrupt vector per pending bit
  localparam logic [6:0] VEC_TABLE [IRQ_W] = '{7'h40, 7'h48, 7'h50, 7'h58, 7'h60};

  typedef struct packed {
    logic [IRQ_W-1:0] irq_requests;
    logic             access_valid;
    logic             req_type;
    logic [7:0]       reg_offset;
    logic [7:0]       write_data;
  } item_t;

  typedef struct packed {
    logic       int_asserted;
    logic       vector_valid;
    logic [6:0] int_vector;
    logic [7:0] read_data;
    logic       addr_hit;
  } result_t;

endpackage

/* src/divider_timer_interrupt_controller_top.sv */
// divider_timer_interrupt_controller_top: stream wrapper with input and
// result registers around the tick core
// depends on dtic_pkg and dtic_core
//
// channel | direction | tdata (low bit up)                              | tuser
// in_     | slave     | irq_requests, access_valid, reg_offset, wr_data | req_type
// out_    | master    | int_asserted, vector_valid, int_vector,         | -
//         |           | read_data, addr_hit                             |
//
// one item per cycle sustained while out_tready stays high; out_tvalid rises
// once an item has passed the input register and the result register in turn
// the whole tick (flag pick, access, divider and timer) is one pass through
// dtic_core between the input register and the result register
// synchronous active-low reset clears all timer and interrupt state to zero
// a stalled output holds its result; the input register keeps one more item
module divider_timer_interrupt_controller_top import dtic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [4:0] irq_requests, [5] access_valid, [13:6] reg_offset,
  // [21:14] write_data, [23:22] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] int_asserted, [1] vector_valid, [8:2] int_vector,
  // [16:9] read_data, [17] addr_hit, [23:18] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  item_t   in_item_r;
  logic    in_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  result_t core_res;
  logic    advance;
  logic    load_in;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign load_in   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_item_r.irq_requests <= in_tdata[4:0];
      in_item_r.access_valid <= in_tdata[5];
      in_item_r.reg_offset   <= in_tdata[13:6];
      in_item_r.write_data   <= in_tdata[21:14];
      in_item_r.req_type     <= in_tuser;
    end
  end

  dtic_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .res     (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_res_r.addr_hit, out_res_r.read_data,
                       out_res_r.int_vector, out_res_r.vector_valid,
                       out_res_r.int_asserted};

endmodule

/* src/dtic_core.sv */
// dtic_core: state registers (divider, timer, flags, enable) and the
// per-tick update; result comes out combinationally
// depends on dtic_pkg
module dtic_core import dtic_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t res
);

  logic [DIV_W-1:0] div_r, div_nxt;
  logic [7:0] tima_r, tima_nxt;
  logic [7:0] tma_r, tma_nxt;
  logic [7:0] tac_r, tac_nxt;
  logic [7:0] if_r, if_nxt;
  logic [7:0] ie_r, ie_nxt;

  logic [7:0]       flags_or;
  logic [7:0]       pending;
  logic [7:0]       flags_clr;
  logic             vec_found;
  logic [6:0]       vec;
  logic             is_wr;
  logic             is_rd;
  logic [DIV_W-1:0] div_acc;
  logic [DIV_W-1:0] div_inc;
  logic [7:0]       tima_acc, tma_acc, tac_acc, if_acc, ie_acc;
  logic [3:0]       tap;
  logic             tick;
  logic [8:0]       tima_sum;
  logic [7:0]       rd;
  logic             hit;

  // flag merge and lowest-bit priority pick
  always_comb begin
    flags_or  = if_r | {3'b000, item.irq_requests};
    pending   = flags_or & ie_r;
    flags_clr = flags_or;
    vec_found = 1'b0;
    vec       = '0;
    for (int i = 0; i < IRQ_W; i++) begin
      if (!vec_found && pending[i]) begin
        vec_found    = 1'b1;
        vec          = VEC_TABLE[i];
        flags_clr[i] = 1'b0;
      end
    end
  end

  // register access
  assign is_wr = item.access_valid && (item.req_type == REQ_WRITE);
  assign is_rd = item.access_valid && (item.req_type == REQ_READ);

  always_comb begin
    div_acc  = div_r;
    tima_acc = tima_r;
    tma_acc  = tma_r;
    tac_acc  = tac_r;
    if_acc   = flags_clr;
    ie_acc   = ie_r;
    if (is_wr) begin
      unique case (item.reg_offset)
        OFF_DIV:  div_acc  = '0;
        OFF_TIMA: tima_acc = item.write_data;
        OFF_TMA:  tma_acc  = item.write_data;
        OFF_TAC:  tac_acc  = item.write_data;
        OFF_IF:   if_acc   = item.write_data;
        OFF_IE:   ie_acc   = item.write_data;
        default:  ;
      endcase
    end
  end

  // read mux
  always_comb begin
    rd = '0;
    if (is_rd) begin
      unique case (item.reg_offset)
        OFF_DIV:  rd = div_r[DIV_W-1 -: 8];
        OFF_TIMA: rd = tima_r;
        OFF_TMA:  rd = tma_r;
        OFF_TAC:  rd = tac_r;
        OFF_IF:   rd = flags_clr;
        OFF_IE:   rd = ie_r;
        default:  rd = UNMAPPED_RD;
      endcase
    end
  end

  always_comb begin
    case (item.reg_offset) inside
      OFF_DIV, OFF_TIMA, OFF_TMA, OFF_TAC, OFF_IF, OFF_IE: hit = item.access_valid;
      default: hit = 1'b0;
    endcase
  end

  // divider increment and timer tick on falling edge of the selected tap
  assign div_inc  = div_acc + 1'b1;
  assign tap      = EDGE_TAP[tac_acc[1:0]];
  assign tick     = ((tac_acc & TAC_ENABLE) != '0) && div_acc[tap] && !div_inc[tap];
  assign tima_sum = {1'b0, tima_acc} + 9'd1;

  always_comb begin
    div_nxt  = div_inc;
    tima_nxt = tima_acc;
    tma_nxt  = tma_acc;
    tac_nxt  = tac_acc;
    if_nxt   = if_acc;
    ie_nxt   = ie_acc;
    if (tick) begin
      if (tima_sum[8]) begin
        tima_nxt = tma_acc;
        if_nxt   = if_acc | TIMER_IRQ;
      end else begin
        tima_nxt = tima_sum[7:0];
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= '0;
      tima_r <= '0;
      tma_r  <= '0;
      tac_r  <= '0;
      if_r   <= '0;
      ie_r   <= '0;
    end else if (step_en) begin
      div_r  <= div_nxt;
      tima_r <= tima_nxt;
      tma_r  <= tma_nxt;
      tac_r  <= tac_nxt;
      if_r   <= if_nxt;
      ie_r   <= ie_nxt;
    end
  end

  assign res.int_asserted = (pending != '0);
  assign res.vector_valid = vec_found;
  assign res.int_vector   = vec;
  assign res.read_data    = rd;
  assign res.addr_hit     = hit;

endmodule

/* src/dtic_checker.sv */
// dtic_checker: port-level properties of the controller's result stream
// depends on dtic_pkg; bound to divider_timer_interrupt_controller_top
module dtic_checker import dtic_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // a vector only comes with the interrupt line
  a_vec_needs_int: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("vector without interrupt");

  // no vector means a zero vector field
  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> (out_tdata[8:2] == 7'h00))
    else $error("vector field set without vector_valid");

  // a vector is one of the five table entries
  a_vec_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |->
      (out_tdata[8:2] == 7'h40 || out_tdata[8:2] == 7'h48 ||
       out_tdata[8:2] == 7'h50 || out_tdata[8:2] == 7'h58 ||
       out_tdata[8:2] == 7'h60))
    else $error("illegal vector");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind divider_timer_interrupt_controller_top dtic_checker u_dtic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
